>>> hdl/smatu_pkg.sv
// Package: shared constants, types and decode for the small matrix unit.
`default_nettype none
package smatu_pkg;

   localparam int DIM_DEFAULT = 3;
   localparam int ELEM_W      = 16;
   localparam int RES_W       = 33;
   localparam int PROD_W      = 2 * ELEM_W;
   localparam int MODE_W      = 2;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_TRANS,
      OP_MUL
   } op_type;

   // front side status of the job queue
   typedef struct packed {
      logic full;
      logic bank;
   } jobq_tail_type;

   typedef struct packed {
      logic   push;
      op_type op;
   } jobq_push_type;

   // back side view of the oldest job
   typedef struct packed {
      logic   valid;
      op_type op;
      logic   bank;
   } jobq_head_type;

   // bit 1 selects multiply, else bit 0 selects transpose
   function automatic op_type decode_mode(input logic [MODE_W-1:0] mode);
      op_type op;
      if (mode[1]) begin
         op = OP_MUL;
      end else if (mode[0]) begin
         op = OP_TRANS;
      end else begin
         op = OP_ADD;
      end
      return op;
   endfunction

endpackage
`default_nettype wire

>>> hdl/smatu_ram.sv
// Generic single write, single read RAM with registered read data.
`default_nettype none
module smatu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> hdl/smatu_front.sv
// Front end: mode register, element loading into the store banks, job issue.
`default_nettype none
module smatu_front #(
   parameter int DIM = smatu_pkg::DIM_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_push,
   input  wire logic [smatu_pkg::ELEM_W-1:0]        req_element_value,
   output logic                                     req_full,
   input  wire logic                                csr_valid,
   input  wire logic [smatu_pkg::MODE_W-1:0]        csr_data,
   input  wire smatu_pkg::jobq_tail_type            tail,
   output smatu_pkg::jobq_push_type                 job,
   output logic                                     a_wr_en,
   output logic                                     b_wr_en,
   output logic [$clog2(DIM*DIM):0]                 wr_addr,
   output logic [smatu_pkg::ELEM_W-1:0]             wr_data
);

   localparam int CELLS = DIM * DIM;
   localparam int IW    = $clog2(CELLS);
   localparam int PW    = $clog2(2 * CELLS);

   logic [smatu_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [PW-1:0]                pos_ff, pos_in;
   logic [PW:0]                  pos_next;
   logic [PW:0]                  need;
   logic                         accept;
   logic                         in_a;
   logic                         done;
   logic [IW-1:0]                idx;
   smatu_pkg::op_type            op;

   assign op       = smatu_pkg::decode_mode(mode_ff);
   assign accept   = req_push && !tail.full;
   assign req_full = tail.full;
   assign in_a     = pos_ff < PW'(CELLS);
   assign pos_next = {1'b0, pos_ff} + (PW+1)'(1);
   assign need     = (op == smatu_pkg::OP_TRANS) ? (PW+1)'(CELLS) : (PW+1)'(2 * CELLS);
   assign done     = pos_next >= need;
   assign idx      = in_a ? pos_ff[IW-1:0] : IW'(pos_ff - PW'(CELLS));

   assign a_wr_en  = accept && in_a;
   assign b_wr_en  = accept && !in_a;
   assign wr_addr  = {tail.bank, idx};
   assign wr_data  = req_element_value;
   assign job.push = accept && done;
   assign job.op   = op;

   always_comb begin
      mode_in = csr_valid ? csr_data : mode_ff;
      pos_in  = pos_ff;
      if (accept) begin
         pos_in = done ? '0 : pos_next[PW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= '0;
         pos_ff  <= '0;
      end else begin
         mode_ff <= mode_in;
         pos_ff  <= pos_in;
      end
   end

endmodule
`default_nettype wire

>>> hdl/smatu_jobq.sv
// Two-entry job queue; each slot owns one bank of the element stores.
`default_nettype none
module smatu_jobq (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire smatu_pkg::jobq_push_type job,
   output smatu_pkg::jobq_tail_type      tail,
   output smatu_pkg::jobq_head_type      head,
   input  wire logic                     pop
);

   smatu_pkg::op_type op_ff [2];
   logic              wptr_ff, wptr_in;
   logic              rptr_ff, rptr_in;
   logic [1:0]        count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign do_push   = job.push && (count_ff != 2'd2);
   assign do_pop    = pop && (count_ff != 2'd0);
   assign tail.full = count_ff == 2'd2;
   assign tail.bank = wptr_ff;
   assign head.valid = count_ff != 2'd0;
   assign head.op   = op_ff[rptr_ff];
   assign head.bank = rptr_ff;

   always_comb begin
      wptr_in  = do_push ? !wptr_ff : wptr_ff;
      rptr_in  = do_pop ? !rptr_ff : rptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         op_ff[wptr_ff] <= job.op;
      end
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

>>> hdl/smatu_back.sv
// Back end: walks the result cells, reads the stores, accumulates, outputs.
`default_nettype none
module smatu_back #(
   parameter int DIM = smatu_pkg::DIM_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire smatu_pkg::jobq_head_type            head,
   output logic                                     job_pop,
   output logic [$clog2(DIM*DIM):0]                 a_rd_addr,
   output logic [$clog2(DIM*DIM):0]                 b_rd_addr,
   input  wire logic [smatu_pkg::ELEM_W-1:0]        a_rd_data,
   input  wire logic [smatu_pkg::ELEM_W-1:0]        b_rd_data,
   output logic                                     rsp_empty,
   input  wire logic                                rsp_pop,
   output logic [smatu_pkg::RES_W-1:0]              rsp_result_value,
   output logic                                     rsp_last_element
);

   localparam int CELLS = DIM * DIM;
   localparam int IW    = $clog2(CELLS);
   localparam int CW    = $clog2(DIM);
   localparam int EW    = smatu_pkg::ELEM_W;
   localparam int RW    = smatu_pkg::RES_W;
   localparam int PRW   = smatu_pkg::PROD_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_WAIT,
      S_ACC,
      S_OUT
   } state_type;

   state_type      state_ff, state_in;
   logic [CW-1:0]  row_ff, row_in;
   logic [CW-1:0]  col_ff, col_in;
   logic [CW-1:0]  k_ff, k_in;
   logic [RW-1:0]  term_ff, term_in;
   logic [RW-1:0]  acc_ff, acc_in;
   logic           out_valid_ff, out_valid_in;
   logic [RW-1:0]  out_value_ff, out_value_in;
   logic           out_last_ff, out_last_in;

   logic [IW-1:0]         a_idx;
   logic [IW-1:0]         b_idx;
   logic signed [PRW-1:0] prod;
   logic [EW:0]           sum;
   logic                  last_k;
   logic                  last_row;
   logic                  last_col;
   logic                  slot_free;

   always_comb begin
      unique case (head.op)
         smatu_pkg::OP_MUL: begin
            a_idx = IW'(int'(row_ff) * DIM + int'(k_ff));
            b_idx = IW'(int'(k_ff) * DIM + int'(col_ff));
         end
         smatu_pkg::OP_TRANS: begin
            a_idx = IW'(int'(col_ff) * DIM + int'(row_ff));
            b_idx = IW'(int'(col_ff) * DIM + int'(row_ff));
         end
         default: begin
            a_idx = IW'(int'(row_ff) * DIM + int'(col_ff));
            b_idx = IW'(int'(row_ff) * DIM + int'(col_ff));
         end
      endcase
   end

   assign a_rd_addr = {head.bank, a_idx};
   assign b_rd_addr = {head.bank, b_idx};

   assign prod      = $signed(a_rd_data) * $signed(b_rd_data);
   assign sum       = {a_rd_data[EW-1], a_rd_data} + {b_rd_data[EW-1], b_rd_data};
   assign last_k    = (head.op != smatu_pkg::OP_MUL) || (k_ff == CW'(DIM - 1));
   assign last_row  = row_ff == CW'(DIM - 1);
   assign last_col  = col_ff == CW'(DIM - 1);
   assign slot_free = !out_valid_ff || rsp_pop;

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      k_in         = k_ff;
      term_in      = term_ff;
      acc_in       = acc_ff;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;
      out_valid_in = rsp_pop ? 1'b0 : out_valid_ff;
      job_pop      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               k_in     = '0;
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            unique case (head.op)
               smatu_pkg::OP_MUL:   term_in = {{(RW-PRW){prod[PRW-1]}}, prod};
               smatu_pkg::OP_TRANS: term_in = {{(RW-EW){a_rd_data[EW-1]}}, a_rd_data};
               default:             term_in = {{(RW-EW-1){sum[EW]}}, sum};
            endcase
            state_in = S_ACC;
         end
         S_ACC: begin
            acc_in = (k_ff == '0) ? term_ff : acc_ff + term_ff;
            if (last_k) begin
               state_in = S_OUT;
            end else begin
               k_in     = k_ff + CW'(1);
               state_in = S_READ;
            end
         end
         S_OUT: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_value_in = acc_ff;
               out_last_in  = last_row && last_col;
               k_in         = '0;
               if (last_col) begin
                  col_in = '0;
                  row_in = row_ff + CW'(1);
               end else begin
                  col_in = col_ff + CW'(1);
               end
               if (last_row && last_col) begin
                  row_in   = '0;
                  job_pop  = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      term_ff      <= term_in;
      acc_ff       <= acc_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         k_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         k_ff         <= k_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_result_value = out_value_ff;
   assign rsp_last_element = out_last_ff;

endmodule
`default_nettype wire

>>> hdl/small_matrix_add_transpose_multiply_unit.sv
// Loading takes one element word per cycle unless req_full is high (job queue full).
// Two store banks let a new load overlap a burst; the job of a load is queued when its
// last element is taken, and the back end starts it once idle. Each result cell reads the
// stores, registers the read data, forms the term and accumulates it per product term.
// Synchronous active-high reset clears the mode, load position, job queue and output;
// the element stores are not reset.
`default_nettype none
module small_matrix_add_transpose_multiply_unit #(
   parameter int DIM = smatu_pkg::DIM_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_push,
   output logic                                     req_full,
   input  wire logic signed [smatu_pkg::ELEM_W-1:0] req_element_value,
   output logic                                     rsp_empty,
   input  wire logic                                rsp_pop,
   output logic signed [smatu_pkg::RES_W-1:0]       rsp_result_value,
   output logic                                     rsp_last_element,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [smatu_pkg::MODE_W-1:0]        csr_operation_mode
);

   localparam int CELLS     = DIM * DIM;
   localparam int IW        = $clog2(CELLS);
   localparam int RAM_DEPTH = 2 ** (IW + 1);
   localparam int EW        = smatu_pkg::ELEM_W;
   localparam int RW        = smatu_pkg::RES_W;

   smatu_pkg::jobq_tail_type tail;
   smatu_pkg::jobq_push_type job;
   smatu_pkg::jobq_head_type head;
   logic                     job_pop;
   logic                     a_wr_en;
   logic                     b_wr_en;
   logic [IW:0]              wr_addr;
   logic [EW-1:0]            wr_data;
   logic [IW:0]              a_rd_addr;
   logic [IW:0]              b_rd_addr;
   logic [EW-1:0]            a_rd_data;
   logic [EW-1:0]            b_rd_data;
   logic [RW-1:0]            result_value;

   assign csr_ready = 1'b1;

   smatu_front #(.DIM(DIM)) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_element_value (req_element_value),
      .req_full          (req_full),
      .csr_valid         (csr_valid),
      .csr_data          (csr_operation_mode),
      .tail              (tail),
      .job               (job),
      .a_wr_en           (a_wr_en),
      .b_wr_en           (b_wr_en),
      .wr_addr           (wr_addr),
      .wr_data           (wr_data)
   );

   smatu_jobq u_jobq (
      .clock (clock),
      .reset (reset),
      .job   (job),
      .tail  (tail),
      .head  (head),
      .pop   (job_pop)
   );

   smatu_ram #(.WIDTH(EW), .DEPTH(RAM_DEPTH)) u_store_a (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   smatu_ram #(.WIDTH(EW), .DEPTH(RAM_DEPTH)) u_store_b (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

   smatu_back #(.DIM(DIM)) u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .job_pop          (job_pop),
      .a_rd_addr        (a_rd_addr),
      .b_rd_addr        (b_rd_addr),
      .a_rd_data        (a_rd_data),
      .b_rd_data        (b_rd_data),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_result_value (result_value),
      .rsp_last_element (rsp_last_element)
   );

   assign rsp_result_value = $signed(result_value);

endmodule
`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the small matrix unit: directed and random loads with a predictor.
module testbench;

   localparam int DIM           = smatu_pkg::DIM_DEFAULT;
   localparam int ELEM_W        = smatu_pkg::ELEM_W;
   localparam int RES_W         = smatu_pkg::RES_W;
   localparam int MODE_W        = smatu_pkg::MODE_W;
   localparam int CELLS         = DIM * DIM;
   localparam int RANDOM_WORDS  = 360;
   localparam int SETTLE_CYCLES = 4 * (3 * DIM + 1);
   localparam int IDLE_LIMIT    = 4000;
   localparam int PRINT_LIMIT   = 40;

   localparam logic [MODE_W-1:0]        MODE_MUL_ALT = 2'b11;
   localparam logic signed [ELEM_W-1:0] ELEM_MAX     = {1'b0, {(ELEM_W-1){1'b1}}};
   localparam logic signed [ELEM_W-1:0] ELEM_MIN     = {1'b1, {(ELEM_W-1){1'b0}}};

   typedef struct {
      logic signed [RES_W-1:0] value;
      logic                    last;
   } result_word_type;

   logic                     clock              = 1'b0;
   logic                     reset              = 1'b1;
   logic                     req_push           = 1'b0;
   logic signed [ELEM_W-1:0] req_element_value  = '0;
   logic                     rsp_pop            = 1'b0;
   logic                     csr_valid          = 1'b0;
   logic [MODE_W-1:0]        csr_operation_mode = '0;
   wire                      req_full;
   wire                      rsp_empty;
   wire signed [RES_W-1:0]   rsp_result_value;
   wire                      rsp_last_element;
   wire                      csr_ready;

   // local copy of the unit state
   logic [MODE_W-1:0]        mode_shadow = '0;
   logic signed [ELEM_W-1:0] store_a [CELLS];
   logic signed [ELEM_W-1:0] store_b [CELLS];
   int                       load_count = 0;
   result_word_type          result_queue [$];

   int error_count = 0;
   int burst_left  = 0;
   int random_sent = 0;
   int stall_pct   = 0;
   int stall_left  = 0;
   int idle_cycles = 0;

   small_matrix_add_transpose_multiply_unit #(.DIM(DIM)) uut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_element_value  (req_element_value),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_result_value   (rsp_result_value),
      .rsp_last_element   (rsp_last_element),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_operation_mode (csr_operation_mode)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic int words_needed();
      return (mode_shadow == smatu_pkg::OP_TRANS) ? CELLS : 2 * CELLS;
   endfunction

   function automatic logic signed [ELEM_W-1:0] random_element();
      case ($urandom_range(0, 7))
         0: return ELEM_MAX;
         1: return ELEM_MIN;
         2: return '0;
         3: return '1;
         default: return ELEM_W'($urandom);
      endcase
   endfunction

   // store one element; on the closing element queue the whole result matrix
   task automatic load_element(input logic signed [ELEM_W-1:0] v);
      smatu_pkg::op_type op;
      result_word_type   word;
      longint            acc;
      op = mode_shadow[1] ? smatu_pkg::OP_MUL :
           (mode_shadow[0] ? smatu_pkg::OP_TRANS : smatu_pkg::OP_ADD);
      if (load_count < CELLS) begin
         store_a[load_count] = v;
      end else begin
         store_b[load_count - CELLS] = v;
      end
      load_count++;
      if (load_count >= words_needed()) begin
         load_count = 0;
         for (int r = 0; r < DIM; r++) begin
            for (int c = 0; c < DIM; c++) begin
               case (op)
                  smatu_pkg::OP_MUL: begin
                     acc = 0;
                     for (int k = 0; k < DIM; k++) begin
                        acc += longint'(store_a[r * DIM + k]) * longint'(store_b[k * DIM + c]);
                     end
                  end
                  smatu_pkg::OP_TRANS: acc = longint'(store_a[c * DIM + r]);
                  default: acc = longint'(store_a[r * DIM + c]) +
                                 longint'(store_b[r * DIM + c]);
               endcase
               word.value = acc[RES_W-1:0];
               word.last  = (r == DIM - 1) && (c == DIM - 1);
               result_queue.push_back(word);
            end
         end
      end
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (error_count < PRINT_LIMIT) begin
         $display("mismatch %s at %0t: got %0d, expected %0d", what, $realtime, got, want);
      end
      error_count++;
   endtask

   // one input word; the sender runs in bursts with random gaps
   task automatic send_word(input logic signed [ELEM_W-1:0] v);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_push          <= 1'b1;
      req_element_value <= v;
      do @(posedge clock); while (req_full);
      load_element(v);
      burst_left--;
   endtask

   task automatic send_random_words(input int count);
      repeat (count) begin
         send_word(random_element());
         random_sent++;
      end
   endtask

   // hold off until every queued result is out and the unit has settled
   task automatic wait_idle();
      req_push   <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (result_queue.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_mode(input logic [MODE_W-1:0] m);
      csr_valid          <= 1'b1;
      csr_operation_mode <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      mode_shadow = m;
   endtask

   // reset mode is add; sums at both ends of the range
   task automatic test_add_at_reset_mode();
      for (int i = 0; i < CELLS; i++) begin
         send_word((i % 2) ? ELEM_MIN : ELEM_MAX);
      end
      for (int i = 0; i < CELLS; i++) begin
         send_word((i % 3 == 0) ? ELEM_MAX : ((i % 3 == 1) ? ELEM_MIN : '1));
      end
   endtask

   task automatic test_transpose_extremes();
      int v;
      wait_idle();
      set_mode(smatu_pkg::OP_TRANS);
      for (int i = 0; i < CELLS; i++) begin
         v = i * 4099 - 16384;
         if (i == 0) begin
            send_word(ELEM_MIN);
         end else if (i == CELLS - 1) begin
            send_word(ELEM_MAX);
         end else begin
            send_word(v[ELEM_W-1:0]);
         end
      end
   endtask

   // mode three decodes as multiply; min times min gives the largest sums
   task automatic test_multiply_mode_three();
      wait_idle();
      set_mode(MODE_MUL_ALT);
      repeat (2 * CELLS) send_word(ELEM_MIN);
   endtask

   task automatic test_random_traffic();
      int loads;
      int remaining;
      while (random_sent < RANDOM_WORDS) begin
         wait_idle();
         set_mode(MODE_W'($urandom_range(0, 3)));
         loads = $urandom_range(1, 4);
         repeat (loads) begin
            case ($urandom_range(0, 9))
               0: begin
                  // broken load: mode switch part way through
                  send_random_words($urandom_range(1, 2 * CELLS - 1));
                  wait_idle();
                  set_mode(MODE_W'($urandom_range(0, 3)));
               end
               1: wait_idle();
               default: begin
                  remaining = words_needed() - load_count;
                  send_random_words((remaining < 1) ? 1 : remaining);
               end
            endcase
         end
      end
   endtask

   always @(posedge clock) begin : check_results
      result_word_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (result_queue.size() == 0) begin
            report_mismatch("unexpected result word", longint'(rsp_result_value), 0);
         end else begin
            want = result_queue.pop_front();
            if (rsp_result_value !== want.value) begin
               report_mismatch("result_value", longint'(rsp_result_value),
                               longint'(want.value));
            end
            if (rsp_last_element !== want.last) begin
               report_mismatch("last_element", longint'(rsp_last_element),
                               longint'(want.last));
            end
         end
      end
   end

   always @(posedge clock) begin : drive_pop
      if (stall_left == 0) begin
         case ($urandom_range(0, 2))
            0:       stall_pct = 0;
            1:       stall_pct = 35;
            default: stall_pct = 80;
         endcase
         stall_left = $urandom_range(8, 80);
      end else begin
         stall_left--;
      end
      rsp_pop <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_add_at_reset_mode();
      test_transpose_extremes();
      test_multiply_mode_three();
      test_random_traffic();
      wait_idle();
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> sim.f
hdl/smatu_pkg.sv
hdl/smatu_ram.sv
hdl/smatu_front.sv
hdl/smatu_jobq.sv
hdl/smatu_back.sv
hdl/small_matrix_add_transpose_multiply_unit.sv
verif/testbench.sv
